FILE: hw/rtl/obf_pkg.sv
// ----------------------------------------------------------------------------
// obf_pkg
// Types and constants shared by the outline flattener modules.
// ----------------------------------------------------------------------------
package obf_pkg;

    localparam int unsigned SEG_W    = 7;
    localparam int unsigned MAX_SEGS = 64;
    localparam int unsigned DEN_W    = 19;   // s^3 for s up to 64
    localparam int unsigned DIV_W    = 20;   // twice the denominator
    localparam int unsigned WGT_W    = 20;
    localparam int unsigned ACC_W    = 36;
    localparam int unsigned QUO_W    = 32;
    localparam int unsigned CNT_W    = 5;

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_QUAD  = 2'd2;
    localparam logic [1:0] KIND_CUBIC = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] ctrl1_x;
        logic signed [15:0] ctrl1_y;
        logic signed [15:0] ctrl2_x;
        logic signed [15:0] ctrl2_y;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               contour_start;
        logic               last;
    } point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINE,
        ST_DEN1,
        ST_DEN2,
        ST_WT1,
        ST_WT2,
        ST_MAC,
        ST_DIVI,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       den_sq;
        logic       den_fin;
        logic       wt1;
        logic       wt2;
        logic       mac_en;
        logic       mac_clr;
        logic [1:0] mac_k;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic       out_line;
        logic       pen_upd;
        logic       i_inc;
    } cmd_t;

    typedef struct packed {
        logic in_line;
        logic segs_zero;
        logic i_last;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/obf_dp.sv
// ----------------------------------------------------------------------------
// obf_dp
// Datapath: pen, weights, multiply-accumulate, restoring dividers and
// the output register.
// ----------------------------------------------------------------------------
module obf_dp
    import obf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SEG_W-1:0]     cfg_data,
    input  vertex_t              in_item,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output point_t               out_item
);

    logic [SEG_W-1:0]        segs_reg;
    vertex_t                 v_reg;
    logic signed [15:0]      pen_x_reg, pen_y_reg;
    logic [SEG_W-1:0]        s_reg, i_reg;
    logic [12:0]             sq_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DIV_W-1:0]        d_reg;
    logic [12:0]             mm_reg, ii_reg, mi_reg;
    logic [SEG_W-1:0]        m_reg;
    logic [WGT_W-1:0]        w_reg [4];
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic [DIV_W-1:0]        rem_x_reg, rem_y_reg;
    logic [QUO_W-1:0]        q_x_reg, q_y_reg;
    logic                    out_valid_reg;
    point_t                  out_reg;

    logic [SEG_W-1:0]        m_w;
    logic [WGT_W-1:0]        w_sel;
    logic signed [15:0]      px_sel, py_sel;
    logic signed [36:0]      prod_x, prod_y;
    logic signed [53:0]      n_x, n_y;
    logic [DIV_W:0]          r2_x, r2_y;
    logic                    out_free_w;
    logic                    cubic;

    assign cubic      = (v_reg.kind == KIND_CUBIC);
    assign m_w        = s_reg - i_reg;
    assign out_free_w = !out_valid_reg || out_ready;

    // Status back to the controller.
    assign status.in_line   = (in_item.kind == KIND_MOVE) || (in_item.kind == KIND_LINE);
    assign status.segs_zero = (segs_reg == '0);
    assign status.i_last    = (i_reg == s_reg);
    assign status.out_free  = out_free_w;

    // Segment count register, saturated when a vertex is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segs_reg <= SEG_W'(8);
        end
        else if (cfg_we)
        begin
            segs_reg <= cfg_data;
        end
    end

    // Pen point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end
        else if (cmd.pen_upd)
        begin
            pen_x_reg <= v_reg.end_x;
            pen_y_reg <= v_reg.end_y;
        end
    end

    // Point selection for the multiply-accumulate.
    always_comb
    begin
        w_sel  = w_reg[cmd.mac_k];
        px_sel = pen_x_reg;
        py_sel = pen_y_reg;
        case (cmd.mac_k)
            2'd0:
            begin
                px_sel = pen_x_reg;
                py_sel = pen_y_reg;
            end
            2'd1:
            begin
                px_sel = v_reg.ctrl1_x;
                py_sel = v_reg.ctrl1_y;
            end
            2'd2:
            begin
                px_sel = cubic ? v_reg.ctrl2_x : v_reg.end_x;
                py_sel = cubic ? v_reg.ctrl2_y : v_reg.end_y;
            end
            default:
            begin
                px_sel = v_reg.end_x;
                py_sel = v_reg.end_y;
            end
        endcase
        prod_x = $signed({1'b0, w_sel}) * px_sel;
        prod_y = $signed({1'b0, w_sel}) * py_sel;
    end

    // Dividend offset by 2^31 divisors so the division is unsigned.
    always_comb
    begin
        n_x = (54'(acc_x_reg) <<< 17) + 54'($signed({1'b0, den_reg}))
            + (54'($signed({1'b0, d_reg})) <<< 31);
        n_y = (54'(acc_y_reg) <<< 17) + 54'($signed({1'b0, den_reg}))
            + (54'($signed({1'b0, d_reg})) <<< 31);
        r2_x = {rem_x_reg, q_x_reg[QUO_W-1]};
        r2_y = {rem_y_reg, q_y_reg[QUO_W-1]};
    end

    // Working registers of the curve arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            v_reg <= in_item;
            s_reg <= (segs_reg > SEG_W'(MAX_SEGS)) ? SEG_W'(MAX_SEGS) : segs_reg;
            i_reg <= SEG_W'(1);
        end
        if (cmd.i_inc)
        begin
            i_reg <= i_reg + SEG_W'(1);
        end
        if (cmd.den_sq)
        begin
            sq_reg <= 13'(s_reg) * 13'(s_reg);
        end
        if (cmd.den_fin)
        begin
            den_reg <= cubic ? DEN_W'(sq_reg) * DEN_W'(s_reg) : DEN_W'(sq_reg);
            d_reg   <= cubic ? {DEN_W'(sq_reg) * DEN_W'(s_reg), 1'b0}
                             : {DEN_W'(sq_reg), 1'b0};
        end
        if (cmd.wt1)
        begin
            m_reg  <= m_w;
            mm_reg <= 13'(m_w) * 13'(m_w);
            ii_reg <= 13'(i_reg) * 13'(i_reg);
            mi_reg <= 13'(m_w) * 13'(i_reg);
        end
        if (cmd.wt2)
        begin
            if (cubic)
            begin
                w_reg[0] <= WGT_W'(mm_reg) * WGT_W'(m_reg);
                w_reg[1] <= WGT_W'(3 * mm_reg * i_reg);
                w_reg[2] <= WGT_W'(3 * mi_reg * i_reg);
                w_reg[3] <= WGT_W'(ii_reg) * WGT_W'(i_reg);
            end
            else
            begin
                w_reg[0] <= WGT_W'(mm_reg);
                w_reg[1] <= WGT_W'({mi_reg, 1'b0});
                w_reg[2] <= WGT_W'(ii_reg);
                w_reg[3] <= '0;
            end
        end
        if (cmd.mac_en)
        begin
            acc_x_reg <= cmd.mac_clr ? ACC_W'(prod_x) : acc_x_reg + ACC_W'(prod_x);
            acc_y_reg <= cmd.mac_clr ? ACC_W'(prod_y) : acc_y_reg + ACC_W'(prod_y);
        end
        if (cmd.div_init)
        begin
            rem_x_reg <= n_x[51:32];
            q_x_reg   <= n_x[31:0];
            rem_y_reg <= n_y[51:32];
            q_y_reg   <= n_y[31:0];
        end
        else if (cmd.div_step)
        begin
            // One quotient bit per cycle, shifted in at the bottom.
            if (r2_x >= {1'b0, d_reg})
            begin
                rem_x_reg <= DIV_W'(r2_x - {1'b0, d_reg});
                q_x_reg   <= {q_x_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_x_reg <= r2_x[DIV_W-1:0];
                q_x_reg   <= {q_x_reg[QUO_W-2:0], 1'b0};
            end
            if (r2_y >= {1'b0, d_reg})
            begin
                rem_y_reg <= DIV_W'(r2_y - {1'b0, d_reg});
                q_y_reg   <= {q_y_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_y_reg <= r2_y[DIV_W-1:0];
                q_y_reg   <= {q_y_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Output register: a new item may be loaded while the old one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_line)
            begin
                out_reg.point_x       <= {v_reg.end_x, 16'h0000};
                out_reg.point_y       <= {v_reg.end_y, 16'h0000};
                out_reg.contour_start <= (v_reg.kind == KIND_MOVE);
                out_reg.last          <= 1'b1;
            end
            else
            begin
                out_reg.point_x       <= q_x_reg ^ 32'h8000_0000;
                out_reg.point_y       <= q_y_reg ^ 32'h8000_0000;
                out_reg.contour_start <= 1'b0;
                out_reg.last          <= (i_reg == s_reg);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: hw/rtl/obf_ctrl.sv
// ----------------------------------------------------------------------------
// obf_ctrl
// Controller: sequences each vertex through the datapath, one item at a time.
// ----------------------------------------------------------------------------
module obf_ctrl
    import obf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [1:0]       k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mac_k  = k_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (status.in_line)
                    begin
                        state_next = ST_LINE;
                    end
                    else if (!status.segs_zero)
                    begin
                        state_next = ST_DEN1;
                    end
                end
            end
            ST_LINE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_line = 1'b1;
                    cmd.pen_upd  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DEN1:
            begin
                cmd.den_sq = 1'b1;
                state_next = ST_DEN2;
            end
            ST_DEN2:
            begin
                cmd.den_fin = 1'b1;
                state_next  = ST_WT1;
            end
            ST_WT1:
            begin
                cmd.wt1    = 1'b1;
                state_next = ST_WT2;
            end
            ST_WT2:
            begin
                cmd.wt2    = 1'b1;
                k_next     = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_clr = (k_reg == 2'd0);
                k_next      = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == '1)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.i_last)
                    begin
                        cmd.pen_upd = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_WT1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/outline_bezier_flattener.sv
// ----------------------------------------------------------------------------
// outline_bezier_flattener
// Flattens move, line, quadratic and cubic outline vertices into Q16.16
// points by uniform subdivision of each curve.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready  in_item  (vertex_t)
//  out       output     out_valid/out_ready  out_item (point_t)
//  cfg       input      cfg_we               cfg_data (segments per curve)
//
// A move or line item goes straight from its vertex to the output. A curve
// first squares and then finishes its denominator; for each point it then
// computes the weights, takes four multiply-accumulate steps and runs a
// restoring divider (one quotient bit a cycle) before loading the output.
// Reset returns the pen to 0,0 and the segment count to eight.
// A stalled output holds the next point back but the output register lets
// a finished point wait while the next item is taken.
module outline_bezier_flattener
    import obf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [SEG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  vertex_t          in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output point_t           out_item
);

    cmd_t    cmd;
    status_t status;

    // Controller.
    obf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    obf_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
